// File: rtl/bprq_pkg.sv
// ----------------------------------------------------------------------------
// bprq_pkg: shared types and codes of the bounded priority request queue
// Transfer payloads, status codes, play modes and controller states.
// ----------------------------------------------------------------------------
package bprq_pkg;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // priority classes with a meaning of their own
  localparam logic [1:0] CLS_EMOTION = 2'd0;
  localparam logic [1:0] CLS_RANDOM  = 2'd3;

  // play modes reported for a popped entry
  localparam logic [1:0] MODE_EMOTION = 2'd0;
  localparam logic [1:0] MODE_TIMED   = 2'd1;
  localparam logic [1:0] MODE_RANDOM  = 2'd2;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_EVICTED  = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_POPPED   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    logic        op;
    logic [1:0]  req_class;
    logic [15:0] ref_id;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] out_ref;
    logic [1:0]  out_class;
    logic [1:0]  play_mode;
    logic [3:0]  occupancy;
  } out_item_t;

  // controller commands to the datapath
  typedef struct packed {
    logic load;   // capture the accepted item
    logic exec;   // update the queue and load the result register
  } dp_cmd_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_t;

endpackage

// File: rtl/bounded_priority_request_queue_unit.sv
// ----------------------------------------------------------------------------
// bounded_priority_request_queue_unit: priority-ordered request queue
// Holds up to QUEUE_DEPTH requests sorted by class (0 highest), FIFO within
// a class. An input transfer carries op (enqueue or dequeue), req_class and
// ref_id; each input transfer yields exactly one result transfer with status,
// out_ref, out_class, play_mode and occupancy.
// Both channels use valid/stall: a transfer happens on a clock edge with
// valid high and stall low.
// The result is registered: an accepted item is captured and the controller
// enters its execute state, in which every slot compares its class and shifts;
// the result then sits in the output register and can transfer from there.
// The controller's capture/execute sequence takes no new item before the last
// one has executed; in_stall is high during the execute cycle.
// The result sits in an output register; a new item is taken while it waits
// unless the receiver stalls it, in which case in_stall stays high until the
// result transfers.
// Reset (rst_n low, synchronous) empties the queue; no clearing pass runs.
// ----------------------------------------------------------------------------
module bounded_priority_request_queue_unit #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bprq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bprq_pkg::out_item_t out_data
);

  bprq_pkg::dp_cmd_t cmd;

  // sequencing
  bprq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // queue storage and result
  bprq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

`ifndef SYNTH
  // an execute cycle always presents a result next
  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("execute did not produce a result");

  // the result register is empty when execute writes it
  a_exec_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !out_valid)
    else $error("result overwritten before transfer");

  // an accepted item blocks the input for its execute cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken during execute");
`endif

endmodule

// File: rtl/bprq_ctrl.sv
// ----------------------------------------------------------------------------
// bprq_ctrl: sequencing controller
// Accepts one item, runs its execute state, and tracks the result register.
// ----------------------------------------------------------------------------
module bprq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output bprq_pkg::dp_cmd_t cmd
);

  bprq_pkg::ctrl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  in_xfer;

  // state and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bprq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // busy while executing, or while a stalled result holds the output register
  assign in_stall = (state_r == bprq_pkg::S_EXEC) || (out_valid_r && out_stall);
  assign in_xfer  = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      bprq_pkg::S_IDLE: begin
        if (in_xfer) begin
          cmd.load  = 1'b1;
          state_nxt = bprq_pkg::S_EXEC;
        end
      end
      bprq_pkg::S_EXEC: begin
        cmd.exec      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = bprq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bprq_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/bprq_dpath.sv
// ----------------------------------------------------------------------------
// bprq_dpath: queue slots, fill count and result register
// Sorted insert by per-slot compare and shift; pop by shift toward the head.
// ----------------------------------------------------------------------------
module bprq_dpath #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bprq_pkg::dp_cmd_t   cmd,
  input  bprq_pkg::in_item_t  in_data,
  output bprq_pkg::out_item_t out_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bprq_pkg::in_item_t  item_r;
  bprq_pkg::out_item_t out_r, out_nxt;
  logic [15:0]         slot_ref_r   [QUEUE_DEPTH];
  logic [1:0]          slot_class_r [QUEUE_DEPTH];
  logic [15:0]         slot_ref_nxt   [QUEUE_DEPTH];
  logic [1:0]          slot_class_nxt [QUEUE_DEPTH];
  logic [CW-1:0]       fill_r, fill_nxt, fill_eff;
  logic [QUEUE_DEPTH-1:0] ahead;
  logic                is_enq, full, empty, evict, drop, do_ins, do_pop;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  // decode of the current item
  assign is_enq   = (item_r.op == bprq_pkg::OP_ENQ);
  assign full     = (fill_r == CW'(QUEUE_DEPTH));
  assign empty    = (fill_r == '0);
  assign evict    = is_enq && full && (item_r.req_class == bprq_pkg::CLS_EMOTION);
  assign drop     = is_enq && full && (item_r.req_class != bprq_pkg::CLS_EMOTION);
  assign do_ins   = is_enq && !drop;
  assign do_pop   = !is_enq && !empty;
  assign fill_eff = evict ? fill_r - CW'(1) : fill_r;

  // per-slot update: keep, take the new entry, or shift by one
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    // entries of equal or better class stay ahead of the new one
    assign ahead[i] = (CW'(i) < fill_eff) && !(slot_class_r[i] > item_r.req_class);

    always_comb begin
      slot_ref_nxt[i]   = slot_ref_r[i];
      slot_class_nxt[i] = slot_class_r[i];
      if (do_ins && !ahead[i]) begin
        if (i == 0) begin
          slot_ref_nxt[i]   = item_r.ref_id;
          slot_class_nxt[i] = item_r.req_class;
        end else if (ahead[(i == 0) ? 0 : i-1]) begin
          slot_ref_nxt[i]   = item_r.ref_id;
          slot_class_nxt[i] = item_r.req_class;
        end else begin
          slot_ref_nxt[i]   = slot_ref_r[(i == 0) ? 0 : i-1];
          slot_class_nxt[i] = slot_class_r[(i == 0) ? 0 : i-1];
        end
      end else if (do_pop && (i < QUEUE_DEPTH - 1)) begin
        slot_ref_nxt[i]   = slot_ref_r[(i < QUEUE_DEPTH - 1) ? i+1 : i];
        slot_class_nxt[i] = slot_class_r[(i < QUEUE_DEPTH - 1) ? i+1 : i];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        slot_ref_r[i]   <= slot_ref_nxt[i];
        slot_class_r[i] <= slot_class_nxt[i];
      end
    end
  end

  // fill count and result fields
  always_comb begin
    fill_nxt          = fill_r;
    out_nxt.status    = bprq_pkg::ST_INSERTED;
    out_nxt.out_ref   = '0;
    out_nxt.out_class = '0;
    out_nxt.play_mode = bprq_pkg::MODE_EMOTION;
    if (!is_enq) begin
      if (empty) begin
        out_nxt.status = bprq_pkg::ST_EMPTY;
      end else begin
        out_nxt.status    = bprq_pkg::ST_POPPED;
        out_nxt.out_ref   = slot_ref_r[0];
        out_nxt.out_class = slot_class_r[0];
        if (slot_class_r[0] == bprq_pkg::CLS_EMOTION) begin
          out_nxt.play_mode = bprq_pkg::MODE_EMOTION;
        end else if (slot_class_r[0] == bprq_pkg::CLS_RANDOM) begin
          out_nxt.play_mode = bprq_pkg::MODE_RANDOM;
        end else begin
          out_nxt.play_mode = bprq_pkg::MODE_TIMED;
        end
        fill_nxt = fill_r - CW'(1);
      end
    end else if (drop) begin
      out_nxt.status = bprq_pkg::ST_DROPPED;
    end else begin
      // on a full queue the tail is the last slot
      if (evict) begin
        out_nxt.status    = bprq_pkg::ST_EVICTED;
        out_nxt.out_ref   = slot_ref_r[QUEUE_DEPTH-1];
        out_nxt.out_class = slot_class_r[QUEUE_DEPTH-1];
      end
      fill_nxt = fill_eff + CW'(1);
    end
    out_nxt.occupancy = 4'(fill_nxt);
  end

  // fill count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.exec) begin
      fill_r <= fill_nxt;
    end
  end

  // result register, written only while it is empty
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule
